// ----- sv/tcf_pkg.sv -----
// Shared constants, types and tables for the tilt complementary filter.
package tcf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ATAN_DEPTH      = 24;
    localparam int CORDIC_ITERS    = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam int ITER_W          = $clog2(CORDIC_ITERS);
    localparam int ATAN_IDX_W      = $clog2(ATAN_DEPTH);

    localparam int XY_W = 34;
    localparam int Z_W  = 35;

    localparam longint PI_Q30_L = 64'sd3373259426;
    localparam logic signed [Z_W-1:0] PI_Q30 = Z_W'(PI_Q30_L);

    localparam int ROUND_SH = 30 - ANGLE_FRAC_BITS;
    localparam longint ANGLE_LIM = (PI_Q30_L + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
    localparam longint ACC_HI_L = (ANGLE_LIM > 32767) ? 32767 : ANGLE_LIM;
    localparam longint ACC_LO_L = (-ANGLE_LIM < -32768) ? -32768 : -ANGLE_LIM;
    localparam logic signed [Z_W-1:0] ACC_HI = Z_W'(ACC_HI_L);
    localparam logic signed [Z_W-1:0] ACC_LO = Z_W'(ACC_LO_L);
    localparam logic signed [15:0] ACC_HI16 = 16'(ACC_HI_L);
    localparam logic signed [15:0] ACC_LO16 = 16'(ACC_LO_L);

    localparam int GYRO_SH  = ANGLE_FRAC_BITS + 16 - 28;
    localparam int GYRO_LSH = (GYRO_SH >= 0) ? GYRO_SH : 0;
    localparam int GYRO_RSH = (GYRO_SH < 0) ? -GYRO_SH : 0;
    localparam int GYRO_RND = (GYRO_RSH > 0) ? GYRO_RSH - 1 : 0;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int EST_W   = 32;
    localparam int G_W     = 48;
    localparam int G_SPLIT = 18;
    localparam int SUM_W   = 64;

    localparam logic [16:0] BLEND_ONE = 17'd65536;

    localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd65210;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd328;

    localparam logic REG_BLEND_WEIGHT  = 1'b0;
    localparam logic REG_SAMPLE_PERIOD = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                  zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [15:0]     rate;
    } tcf_job_t;

    typedef struct packed {
        logic signed [15:0] acc;
        logic signed [15:0] rate;
    } tcf_res_t;

    // atan(2^-i) in Q0.30
    function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/tcf_front.sv -----
// Input stage: takes samples, pre-rotates into the right half plane, builds a job.
module tcf_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic              q_full,
    output logic              q_push,
    output tcf_pkg::tcf_job_t q_job
);

    logic signed [15:0]             ax;
    logic signed [15:0]             ay;
    logic signed [tcf_pkg::XY_W-1:0] x0;
    logic signed [tcf_pkg::XY_W-1:0] y0;

    assign ax = s_tdata[15:0];
    assign ay = s_tdata[31:16];
    assign x0 = tcf_pkg::XY_W'(ay) <<< 14;
    assign y0 = tcf_pkg::XY_W'(ax) <<< 14;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_job.zero = (ax == 16'sd0) && (ay == 16'sd0);
        q_job.rate = s_tdata[47:32];
        if (ay[15])
        begin
            q_job.x = -x0;
            q_job.y = -y0;
            q_job.z = ax[15] ? -tcf_pkg::PI_Q30 : tcf_pkg::PI_Q30;
        end
        else
        begin
            q_job.x = x0;
            q_job.y = y0;
            q_job.z = '0;
        end
    end

endmodule

// ----- sv/tcf_queue.sv -----
// Short job queue between the input stage and the compute back end.
module tcf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcf_pkg::tcf_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tcf_pkg::tcf_job_t head_job
);

    tcf_pkg::tcf_job_t                mem_reg [tcf_pkg::Q_DEPTH];
    logic [tcf_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [tcf_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [tcf_pkg::Q_CNT_W-1:0]      count_reg;
    logic [tcf_pkg::Q_CNT_W-1:0]      count_next;

    assign full       = (count_reg == tcf_pkg::Q_CNT_W'(tcf_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && head_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && head_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- sv/tcf_cordic.sv -----
// Iterative vectoring CORDIC, one micro-rotation per cycle, gives atan2 in Q2.13.
module tcf_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  tcf_pkg::tcf_job_t job,
    output logic              job_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output tcf_pkg::tcf_res_t res
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_HOLD} cstate_t;

    cstate_t                           state_reg;
    logic [tcf_pkg::ITER_W-1:0]        cnt_reg;
    logic signed [tcf_pkg::XY_W-1:0]   x_reg;
    logic signed [tcf_pkg::XY_W-1:0]   y_reg;
    logic signed [tcf_pkg::Z_W-1:0]    z_reg;
    logic                              zero_reg;
    logic signed [15:0]                rate_reg;

    logic signed [tcf_pkg::XY_W-1:0]   dx;
    logic signed [tcf_pkg::XY_W-1:0]   dy;
    logic signed [tcf_pkg::Z_W-1:0]    step;
    logic signed [tcf_pkg::Z_W-1:0]    z_rnd;
    logic signed [15:0]                acc;

    assign dx   = y_reg >>> cnt_reg;
    assign dy   = x_reg >>> cnt_reg;
    assign step = tcf_pkg::Z_W'(tcf_pkg::atan_q30(tcf_pkg::ATAN_IDX_W'(cnt_reg)));

    assign z_rnd = (z_reg + (tcf_pkg::Z_W'(1) <<< (tcf_pkg::ROUND_SH - 1))) >>> tcf_pkg::ROUND_SH;

    always_comb
    begin
        priority if (zero_reg)
            acc = '0;
        else if (z_rnd > tcf_pkg::ACC_HI)
            acc = tcf_pkg::ACC_HI16;
        else if (z_rnd < tcf_pkg::ACC_LO)
            acc = tcf_pkg::ACC_LO16;
        else
            acc = z_rnd[15:0];
    end

    assign job_pop   = (state_reg == C_IDLE) && job_valid;
    assign res_valid = (state_reg == C_HOLD);
    assign res.acc   = acc;
    assign res.rate  = rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= C_RUN;
                        cnt_reg   <= '0;
                    end
                end
                C_RUN:
                begin
                    if (cnt_reg == tcf_pkg::ITER_W'(tcf_pkg::CORDIC_ITERS - 1))
                        state_reg <= C_HOLD;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                C_HOLD:
                begin
                    if (res_ready)
                        state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            x_reg    <= job.x;
            y_reg    <= job.y;
            z_reg    <= job.z;
            zero_reg <= job.zero;
            rate_reg <= job.rate;
        end
        else if (state_reg == C_RUN)
        begin
            if (!y_reg[tcf_pkg::XY_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step;
            end
        end
    end

endmodule

// ----- sv/tcf_blend.sv -----
// Gyro integration and weighted blend on one shared multiplier; holds the fused state.
module tcf_blend (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       blend_weight,
    input  logic [15:0]       sample_period,
    input  logic              res_valid,
    output logic              res_ready,
    input  tcf_pkg::tcf_res_t res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata
);

    typedef enum logic [2:0] {
        B_IDLE, B_RATE, B_GYRO, B_MLO, B_MHI, B_MACC, B_MADD, B_DONE
    } bstate_t;

    bstate_t                              state_reg;
    logic signed [tcf_pkg::EST_W-1:0]     est_reg;
    logic signed [tcf_pkg::PROD_W-1:0]    prod_reg;
    logic signed [tcf_pkg::G_W-1:0]       g_reg;
    logic signed [tcf_pkg::SUM_W-1:0]     sum_reg;
    logic signed [15:0]                   acc_reg;
    logic signed [15:0]                   rate_reg;
    logic                                 out_valid_reg;
    logic [47:0]                          out_data_reg;

    logic signed [tcf_pkg::MUL_A_W-1:0]   opa;
    logic signed [tcf_pkg::MUL_B_W-1:0]   opb;
    logic signed [tcf_pkg::PROD_W-1:0]    mul_p;
    logic signed [tcf_pkg::G_W-1:0]       p_ext;
    logic signed [tcf_pkg::G_W-1:0]       p_scaled;
    logic [16:0]                          w_acc;
    logic signed [tcf_pkg::SUM_W-1:0]     f_shr;
    logic signed [tcf_pkg::EST_W-1:0]     est_next;
    logic                                 out_free;

    assign w_acc = tcf_pkg::BLEND_ONE - {1'b0, blend_weight};

    always_comb
    begin
        unique case (state_reg)
            B_RATE:
            begin
                opa = $signed({2'b00, sample_period});
                opb = tcf_pkg::MUL_B_W'(rate_reg);
            end
            B_MLO:
            begin
                opa = $signed({2'b00, blend_weight});
                opb = $signed({{(tcf_pkg::MUL_B_W - tcf_pkg::G_SPLIT){1'b0}},
                               g_reg[tcf_pkg::G_SPLIT-1:0]});
            end
            B_MHI:
            begin
                opa = $signed({2'b00, blend_weight});
                opb = tcf_pkg::MUL_B_W'(g_reg >>> tcf_pkg::G_SPLIT);
            end
            default:
            begin
                opa = $signed({1'b0, w_acc});
                opb = tcf_pkg::MUL_B_W'(acc_reg);
            end
        endcase
    end

    assign mul_p = opa * opb;

    assign p_ext = tcf_pkg::G_W'(prod_reg);

    always_comb
    begin
        if (tcf_pkg::GYRO_RSH > 0)
            p_scaled = (p_ext + (tcf_pkg::G_W'(1) <<< tcf_pkg::GYRO_RND)) >>> tcf_pkg::GYRO_RSH;
        else
            p_scaled = p_ext <<< tcf_pkg::GYRO_LSH;
    end

    assign f_shr = (sum_reg + tcf_pkg::SUM_W'(32768)) >>> 16;

    always_comb
    begin
        priority if (f_shr > tcf_pkg::SUM_W'(64'sh7FFF_FFFF))
            est_next = {1'b0, {(tcf_pkg::EST_W - 1){1'b1}}};
        else if (f_shr < -tcf_pkg::SUM_W'(64'sh8000_0000))
            est_next = {1'b1, {(tcf_pkg::EST_W - 1){1'b0}}};
        else
            est_next = f_shr[tcf_pkg::EST_W-1:0];
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign res_ready = (state_reg == B_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            est_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: if (res_valid) state_reg <= B_RATE;
                B_RATE: state_reg <= B_GYRO;
                B_GYRO: state_reg <= B_MLO;
                B_MLO:  state_reg <= B_MHI;
                B_MHI:  state_reg <= B_MACC;
                B_MACC: state_reg <= B_MADD;
                B_MADD: state_reg <= B_DONE;
                B_DONE:
                begin
                    if (out_free)
                    begin
                        est_reg   <= est_next;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && res_valid)
        begin
            acc_reg  <= res.acc;
            rate_reg <= res.rate;
        end
        if (state_reg == B_RATE || state_reg == B_MLO || state_reg == B_MHI
            || state_reg == B_MACC)
            prod_reg <= mul_p;
        if (state_reg == B_GYRO)
            g_reg <= tcf_pkg::G_W'(est_reg) + p_scaled;
        if (state_reg == B_MHI)
            sum_reg <= tcf_pkg::SUM_W'(prod_reg);
        if (state_reg == B_MACC)
            sum_reg <= sum_reg + (tcf_pkg::SUM_W'(prod_reg) <<< tcf_pkg::G_SPLIT);
        if (state_reg == B_MADD)
            sum_reg <= sum_reg + (tcf_pkg::SUM_W'(prod_reg) <<< 16);
        if (state_reg == B_DONE && out_free)
            out_data_reg <= {rate_reg, acc_reg, est_next[tcf_pkg::EST_W-1:16]};
    end

endmodule

// ----- sv/tilt_complementary_filter_core.sv -----
// Top level of the tilt complementary filter: stream ports, register port, front/back split.
//
// One result transaction per input transaction, in order. A sample passes the input
// stage into a two-deep job queue in the cycle it is accepted; the back end then takes
// the job, runs CORDIC_STEPS (16) micro-rotations in the iterative CORDIC unit, hands
// the result over, and steps through the blend sequencer (B_RATE to B_DONE), whose single 18x32
// multiplier does the rate*dt product and the three blend partial products in turn.
// Throughput is set by the CORDIC unit (take, 16 iterations, hand-over); the blend
// sequence overlaps the next CORDIC job. A stalled output holds the blend sequencer,
// then the CORDIC unit, then the queue and the input.
// Registers: blend_weight at 0x0, sample_period at 0x4, both 16 bits in pwdata[15:0].
module tilt_complementary_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], gyro_rate[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // fused_angle[15:0], accel_angle[31:16], rate_echo[47:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]       blend_weight_reg;
    logic [15:0]       sample_period_reg;
    logic              cfg_wr;

    logic              q_full;
    logic              q_push;
    tcf_pkg::tcf_job_t q_job;
    logic              head_valid;
    tcf_pkg::tcf_job_t head_job;
    logic              job_pop;
    logic              res_valid;
    logic              res_ready;
    tcf_pkg::tcf_res_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg  <= tcf_pkg::BLEND_WEIGHT_RST;
            sample_period_reg <= tcf_pkg::SAMPLE_PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                tcf_pkg::REG_BLEND_WEIGHT:  blend_weight_reg  <= pwdata[15:0];
                tcf_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[15:0];
                default:                    blend_weight_reg  <= blend_weight_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == tcf_pkg::REG_SAMPLE_PERIOD) ? {16'd0, sample_period_reg}
                                                             : {16'd0, blend_weight_reg};

    tcf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    tcf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tcf_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tcf_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .blend_weight  (blend_weight_reg),
        .sample_period (sample_period_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

// ----- sv/tcf_checker.sv -----
// Port-level checks for the tilt complementary filter, bound to the top level.
module tcf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= tcf_pkg::ACC_HI16)
                  && ($signed(m_tdata[31:16]) >= tcf_pkg::ACC_LO16))
        else $error("accel angle outside +-pi");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        |=> (!psel || pwrite || (paddr != $past(paddr))
             || (prdata[15:0] == $past(pwdata[15:0]))))
        else $error("register readback mismatch");

    a_rd_upper: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[31:16] == 16'd0 && pready)
        else $error("register read upper bits not zero");

endmodule

bind tilt_complementary_filter_core tcf_checker u_tcf_checker (.*);

// ----- bench/tilt_complementary_filter_core_test.sv -----
// Self-checking bench for the tilt filter core: CORDIC tilt, gyro fusion, register port.
module tilt_complementary_filter_core_test;

    localparam logic [2:0] ADDR_BLEND_WEIGHT  = {tcf_pkg::REG_BLEND_WEIGHT, 2'b00};
    localparam logic [2:0] ADDR_SAMPLE_PERIOD = {tcf_pkg::REG_SAMPLE_PERIOD, 2'b00};
    localparam int PHASES        = 12;
    localparam int PHASE_SAMPLES = 125;
    localparam int LONG_STALL    = 300;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic signed [15:0] fused;
        logic signed [15:0] tilt;
        logic signed [15:0] rate;
    } tilt_result_t;

    class tilt_scoreboard;
        longint       atan_tab[24];
        logic [15:0]  alpha;
        logic [15:0]  dt;
        int           angle_est;
        tilt_result_t pending[$];
        int           errors;
        int           samples;

        function new();
            atan_tab = '{843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                         262143, 131071, 65535, 32767, 16383, 8191,
                         4095, 2047, 1023, 511, 255, 127};
            alpha     = tcf_pkg::BLEND_WEIGHT_RST;
            dt        = tcf_pkg::SAMPLE_PERIOD_RST;
            angle_est = 0;
            errors    = 0;
            samples   = 0;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void set_reg(logic [2:0] addr, logic [15:0] value);
            if (addr == ADDR_BLEND_WEIGHT)
                alpha = value;
            else if (addr == ADDR_SAMPLE_PERIOD)
                dt = value;
        endfunction

        function longint to_angle(longint v);
            int s;
            s = 30 - tcf_pkg::ANGLE_FRAC_BITS;
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function logic signed [15:0] tilt_of(longint num, longint den);
            longint x, y, z, dx, dy, r, lim;
            if (num == 0 && den == 0)
                return 16'sd0;
            x = den * 16384;
            y = num * 16384;
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? tcf_pkg::PI_Q30_L : -tcf_pkg::PI_Q30_L;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < tcf_pkg::CORDIC_ITERS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx;
                    y -= dy;
                    z += atan_tab[i];
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_tab[i];
                end
            end
            r   = to_angle(z);
            lim = to_angle(tcf_pkg::PI_Q30_L);
            if (r > lim)    r = lim;
            if (r < -lim)   r = -lim;
            if (r > 32767)  r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        endfunction

        // accepted sample: advance the fused angle and queue the result
        function void note_sample(logic [47:0] d);
            longint ax, ay, gr, acc, p, g, a, f;
            int sh;
            tilt_result_t res;
            ax  = longint'($signed(d[15:0]));
            ay  = longint'($signed(d[31:16]));
            gr  = longint'($signed(d[47:32]));
            acc = longint'(tilt_of(ax, ay));
            p   = gr * longint'({1'b0, dt});
            sh  = tcf_pkg::ANGLE_FRAC_BITS + 16 - 28;
            if (sh >= 0)
                p = p * (64'sd1 <<< sh);
            else
                p = (p + (64'sd1 <<< (-sh - 1))) >>> (-sh);
            g = longint'(angle_est) + p;
            a = longint'({1'b0, alpha});
            f = a * g + (65536 - a) * (acc * 65536);
            f = (f + 32768) >>> 16;
            if (f > 64'sd2147483647)  f = 64'sd2147483647;
            if (f < -64'sd2147483648) f = -64'sd2147483648;
            angle_est = int'(f);
            res.fused = 16'(angle_est >>> 16);
            res.tilt  = 16'(acc);
            res.rate  = d[47:32];
            pending.push_back(res);
            samples++;
        endfunction

        function void check_result(logic [47:0] d);
            tilt_result_t e;
            if (pending.size() == 0)
            begin
                fail($sformatf("unexpected result transaction %h", d));
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.fused || d[31:16] !== e.tilt || d[47:32] !== e.rate)
                fail($sformatf({"mismatch: fused exp %0d got %0d, tilt exp %0d got %0d,",
                                " rate exp %0d got %0d"},
                               e.fused, $signed(d[15:0]), e.tilt, $signed(d[31:16]),
                               e.rate, $signed(d[47:32])));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tilt_scoreboard sb;
    bit no_idle;
    bit hold_req;
    int settings_used;

    tilt_complementary_filter_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_idle  = 1'b0;
        hold_req = 1'b0;
        settings_used = 0;
        sb = new();
    end

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tilt_complementary_filter_core_test: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int long_left;
        int stall_left;
        long_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                long_left = LONG_STALL;
            end
            if (long_left > 0)
            begin
                long_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(addr, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[15:0] !== value)
            sb.fail($sformatf("register %0d reads %h, wrote %h", addr, prdata[15:0], value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_filter(input logic [15:0] alpha, input logic [15:0] dt);
        write_reg(ADDR_BLEND_WEIGHT, alpha);
        write_reg(ADDR_SAMPLE_PERIOD, dt);
        settings_used++;
    endtask

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] gr);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {gr, ay, ax};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0:       return 16'($signed($urandom_range(0, 128)) - 64);
            1:       return 16'h8000;
            2:       return 16'h7fff;
            3:       return 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(64000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(1, 1000));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial
    begin
        logic [15:0] gr;
        @(negedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: axis extremes, both-zero, tilt clamp near +-pi
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'd0, 16'h7fff);
        send_sample(16'h8000, 16'd0, 16'h8000);
        send_sample(16'd0, 16'h7fff, 16'd100);
        send_sample(16'd0, 16'h8000, 16'hff00);
        send_sample(16'd1, 16'h8000, 16'd0);
        send_sample(16'hffff, 16'h8000, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h7fff);
        send_sample(16'h7fff, 16'h7fff, 16'h8000);
        send_sample(16'h7fff, 16'h8000, 16'd1);
        send_sample(16'h8000, 16'h7fff, 16'hffff);
        send_sample(16'hffff, 16'hffff, 16'd0);
        drain();

        // gyro only, max weight and period: fused angle saturates both ways
        set_filter(16'hffff, 16'hffff);
        repeat (3) send_sample(16'd0, 16'd0, 16'h7fff);
        repeat (4) send_sample(16'd0, 16'd0, 16'h8000);
        drain();

        // no gyro weight and zero period
        set_filter(16'd0, 16'd0);
        send_sample(16'd5, 16'hfff9, 16'd1234);
        send_sample(16'h8000, 16'h7fff, 16'hffff);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_filter(16'hffff, 16'd1);
                1:       set_filter(16'd0, 16'hffff);
                2:       set_filter(tcf_pkg::BLEND_WEIGHT_RST, tcf_pkg::SAMPLE_PERIOD_RST);
                3:       set_filter(16'h8000, 16'hffff);
                default: set_filter(pick_weight(), pick_period());
            endcase
            no_idle = (ph == PHASES - 1);
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (ph == 4 && n == 10)
                    hold_req = 1'b1;
                gr = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 512)) - 256)
                                                 : 16'($urandom);
                send_sample(pick_axis(), pick_axis(), gr);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d samples under %0d filter settings, with axis extremes,",
                 sb.samples, settings_used);
        $display("pi clamp, fused saturation, zero period and a %0d-cycle output stall",
                 LONG_STALL);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tilt_complementary_filter_core_test: done, clean");
        else
            $display("tilt_complementary_filter_core_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tcf_pkg.sv
sv/tcf_front.sv
sv/tcf_queue.sv
sv/tcf_cordic.sv
sv/tcf_blend.sv
sv/tilt_complementary_filter_core.sv
sv/tcf_checker.sv
bench/tilt_complementary_filter_core_test.sv
